>>> rtl/qsgj_pkg.sv
// ----------------------------------------------------------------------------
// qsgj_pkg: shared types and constants for the quad4 gradient/Jacobian block
// Gauss-point gradient constants, lane counts and the sideband struct that
// travels with each point through the divider pipeline.
// ----------------------------------------------------------------------------
package qsgj_pkg;

  // coordinate and result word
  localparam int CW  = 32;
  // wide working word for numerators and determinant
  localparam int WW  = 64;
  // quotient bits produced by the divider
  localparam int QW  = 32;
  // gradient lanes: x and y for each of the four nodes
  localparam int NL  = 8;
  // nodes per element
  localparam int NN  = 4;

  // local gradient constants in Q1.30: 0.25*(1-g) and 0.25*(1+g)
  localparam logic signed [30:0] GA_C = 31'sd113454173;
  localparam logic signed [30:0] GB_C = 31'sd423416739;

  // Gauss point numbers
  localparam logic [1:0] PT_MM = 2'd0;
  localparam logic [1:0] PT_PM = 2'd1;
  localparam logic [1:0] PT_PP = 2'd2;
  localparam logic [1:0] PT_MP = 2'd3;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    logic [1:0] idx;
    logic       last;
  } pt_t;

  typedef struct packed {
    pt_t           pt;
    logic          singular;
    logic [CW-1:0] vol;
  } side_t;

  // clamp to the signed 32-bit range
  function automatic logic [CW-1:0] sat32(input logic signed [65:0] v);
    logic [CW-1:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -66'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  // magnitude of a signed 64-bit word as unsigned
  function automatic logic [WW-1:0] mag64(input logic signed [WW-1:0] v);
    logic [WW-1:0] r;
    r = v[WW-1] ? WW'(-v) : WW'(v);
    return r;
  endfunction

endpackage

>>> rtl/qsgj_seq.sv
// ----------------------------------------------------------------------------
// qsgj_seq: element holder and Gauss-point sequencer
// Holds one element and issues its four Gauss points, one per advance.
// ----------------------------------------------------------------------------
module qsgj_seq import qsgj_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  input  coord_t x_i [NN],
  input  coord_t y_i [NN],
  input  logic   adv_i,
  output logic   in_stall_o,
  output logic   pt_valid_o,
  output pt_t    pt_o,
  output coord_t x_o [NN],
  output coord_t y_o [NN]
);

  logic       elem_vld_q;
  logic [1:0] k_q;
  coord_t     x_q [NN];
  coord_t     y_q [NN];
  logic       take;
  logic       done;

  // finish the element when its last point moves on
  assign done       = elem_vld_q && adv_i && (k_q == PT_MP);
  assign in_stall_o = elem_vld_q && !done;
  assign take       = in_valid_i && !in_stall_o;

  // advance the point counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_vld_q <= 1'b0;
      k_q        <= PT_MM;
    end else if (take) begin
      elem_vld_q <= 1'b1;
      k_q        <= PT_MM;
    end else if (done) begin
      elem_vld_q <= 1'b0;
    end else if (elem_vld_q && adv_i) begin
      k_q <= k_q + 2'd1;
    end
  end

  // hold the element coordinates
  always_ff @(posedge clk_i) begin
    if (take) begin
      x_q <= x_i;
      y_q <= y_i;
    end
  end

  assign pt_valid_o = elem_vld_q;
  assign pt_o.idx   = k_q;
  assign pt_o.last  = (k_q == PT_MP);
  assign x_o        = x_q;
  assign y_o        = y_q;

endmodule

>>> rtl/qsgj_jac.sv
// ----------------------------------------------------------------------------
// qsgj_jac: Jacobian, determinant and gradient numerators
// Five register stages: shape products, Jacobian, cofactor products,
// determinant and numerators, then magnitudes and rounding offsets.
// ----------------------------------------------------------------------------
module qsgj_jac import qsgj_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic          pt_valid_i,
  input  pt_t           pt_i,
  input  coord_t        x_i [NN],
  input  coord_t        y_i [NN],
  output logic          vld_o,
  output side_t         side_o,
  output logic [WW-1:0] num_o [NL],
  output logic [WW-1:0] den_o,
  output logic          neg_o [NL]
);

  localparam int SH = 30 - FRAC_BITS;
  localparam logic signed [64:0] NRND = (65'sd1 <<< SH) >>> 1;
  localparam logic signed [64:0] DRND = (65'sd1 <<< FRAC_BITS) >>> 1;

  // ---------------- stage 1: coordinate differences times constants
  logic signed [30:0] cp, cq, cr, cs;
  logic               xi_pos, eta_pos;
  logic signed [32:0] dxa, dxb, dxc, dxd, dya, dyb, dyc, dyd;

  logic               s1_vld_q;
  pt_t                s1_pt_q;
  logic signed [30:0] s1_p_q, s1_q_q, s1_r_q, s1_s_q;
  logic signed [63:0] s1_ax_q, s1_bx_q, s1_cx_q, s1_dx_q;
  logic signed [63:0] s1_ay_q, s1_by_q, s1_cy_q, s1_dy_q;

  always_comb begin
    xi_pos  = (pt_i.idx == PT_PM) || (pt_i.idx == PT_PP);
    eta_pos = (pt_i.idx == PT_PP) || (pt_i.idx == PT_MP);
    cp = eta_pos ? GA_C : GB_C;
    cq = eta_pos ? GB_C : GA_C;
    cr = xi_pos ? GA_C : GB_C;
    cs = xi_pos ? GB_C : GA_C;
    dxa = 33'(x_i[1]) - 33'(x_i[0]);
    dxb = 33'(x_i[2]) - 33'(x_i[3]);
    dxc = 33'(x_i[3]) - 33'(x_i[0]);
    dxd = 33'(x_i[2]) - 33'(x_i[1]);
    dya = 33'(y_i[1]) - 33'(y_i[0]);
    dyb = 33'(y_i[2]) - 33'(y_i[3]);
    dyc = 33'(y_i[3]) - 33'(y_i[0]);
    dyd = 33'(y_i[2]) - 33'(y_i[1]);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_pt_q <= pt_i;
      s1_p_q  <= cp;
      s1_q_q  <= cq;
      s1_r_q  <= cr;
      s1_s_q  <= cs;
      s1_ax_q <= dxa * cp;
      s1_bx_q <= dxb * cq;
      s1_cx_q <= dxc * cr;
      s1_dx_q <= dxd * cs;
      s1_ay_q <= dya * cp;
      s1_by_q <= dyb * cq;
      s1_cy_q <= dyc * cr;
      s1_dy_q <= dyd * cs;
    end
  end

  // ---------------- stage 2: Jacobian entries, rounded and clamped
  function automatic logic [CW-1:0] jent(input logic signed [63:0] a,
                                         input logic signed [63:0] b);
    logic signed [65:0] v;
    v = 66'(a) + 66'(b) + (66'sd1 <<< 29);
    return sat32(v >>> 30);
  endfunction

  logic               s2_vld_q;
  pt_t                s2_pt_q;
  logic signed [30:0] s2_p_q, s2_q_q, s2_r_q, s2_s_q;
  logic signed [31:0] s2_j00_q, s2_j01_q, s2_j10_q, s2_j11_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s2_pt_q  <= s1_pt_q;
      s2_p_q   <= s1_p_q;
      s2_q_q   <= s1_q_q;
      s2_r_q   <= s1_r_q;
      s2_s_q   <= s1_s_q;
      s2_j00_q <= jent(s1_ax_q, s1_bx_q);
      s2_j01_q <= jent(s1_ay_q, s1_by_q);
      s2_j10_q <= jent(s1_cx_q, s1_dx_q);
      s2_j11_q <= jent(s1_cy_q, s1_dy_q);
    end
  end

  // ---------------- stage 3: determinant and cofactor products
  logic               s3_vld_q;
  pt_t                s3_pt_q;
  logic signed [63:0] s3_da_q, s3_db_q;
  logic signed [63:0] s3_j11p_q, s3_j11q_q, s3_j01r_q, s3_j01s_q;
  logic signed [63:0] s3_j00r_q, s3_j00s_q, s3_j10p_q, s3_j10q_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s3_pt_q   <= s2_pt_q;
      s3_da_q   <= s2_j00_q * s2_j11_q;
      s3_db_q   <= s2_j01_q * s2_j10_q;
      s3_j11p_q <= s2_j11_q * s2_p_q;
      s3_j11q_q <= s2_j11_q * s2_q_q;
      s3_j01r_q <= s2_j01_q * s2_r_q;
      s3_j01s_q <= s2_j01_q * s2_s_q;
      s3_j00r_q <= s2_j00_q * s2_r_q;
      s3_j00s_q <= s2_j00_q * s2_s_q;
      s3_j10p_q <= s2_j10_q * s2_p_q;
      s3_j10q_q <= s2_j10_q * s2_q_q;
    end
  end

  // ---------------- stage 4: determinant and numerators, rounded
  function automatic logic signed [WW-1:0] rnd_n(input logic signed [64:0] v);
    return WW'((v + NRND) >>> SH);
  endfunction

  logic signed [64:0]   det;
  logic signed [WW-1:0] n_d [NL];

  logic                 s4_vld_q;
  pt_t                  s4_pt_q;
  logic signed [WW-1:0] s4_dq_q;
  logic signed [WW-1:0] s4_n_q [NL];

  always_comb begin
    det    = 65'(s3_da_q) - 65'(s3_db_q);
    // x lanes: j11*dxi - j01*deta; y lanes: j00*deta - j10*dxi
    n_d[0] = rnd_n(-65'(s3_j11p_q) + 65'(s3_j01r_q));
    n_d[1] = rnd_n(-65'(s3_j00r_q) + 65'(s3_j10p_q));
    n_d[2] = rnd_n(65'(s3_j11p_q) + 65'(s3_j01s_q));
    n_d[3] = rnd_n(-65'(s3_j00s_q) - 65'(s3_j10p_q));
    n_d[4] = rnd_n(65'(s3_j11q_q) - 65'(s3_j01s_q));
    n_d[5] = rnd_n(65'(s3_j00s_q) - 65'(s3_j10q_q));
    n_d[6] = rnd_n(-65'(s3_j11q_q) - 65'(s3_j01r_q));
    n_d[7] = rnd_n(65'(s3_j00r_q) + 65'(s3_j10q_q));
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s4_pt_q <= s3_pt_q;
      s4_dq_q <= WW'((det + DRND) >>> FRAC_BITS);
      s4_n_q  <= n_d;
    end
  end

  // ---------------- stage 5: magnitudes, signs and half-divisor offset
  logic [WW-1:0] ud;
  logic [WW-1:0] un_d [NL];
  logic          ng_d [NL];

  logic          s5_vld_q;
  side_t         s5_side_q;
  logic [WW-1:0] s5_den_q;
  logic [WW-1:0] s5_num_q [NL];
  logic          s5_neg_q [NL];

  always_comb begin
    ud = mag64(s4_dq_q);
    for (int l = 0; l < NL; l++) begin
      un_d[l] = mag64(s4_n_q[l]) + (ud >> 1);
      ng_d[l] = s4_n_q[l][WW-1] ^ s4_dq_q[WW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s5_side_q.pt       <= s4_pt_q;
      s5_side_q.singular <= (s4_dq_q == '0);
      s5_side_q.vol      <= sat32(66'(s4_dq_q));
      s5_den_q           <= ud;
      s5_num_q           <= un_d;
      s5_neg_q           <= ng_d;
    end
  end

  // move valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
    end else if (adv_i) begin
      s1_vld_q <= pt_valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
    end
  end

  assign vld_o  = s5_vld_q;
  assign side_o = s5_side_q;
  assign num_o  = s5_num_q;
  assign den_o  = s5_den_q;
  assign neg_o  = s5_neg_q;

endmodule

>>> rtl/qsgj_div.sv
// ----------------------------------------------------------------------------
// qsgj_div: eight-lane pipelined restoring divider
// One overflow check stage, then one quotient bit per stage for all lanes
// against a shared divisor; the sideband rides along.
// ----------------------------------------------------------------------------
module qsgj_div import qsgj_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic          vld_i,
  input  side_t         side_i,
  input  logic [WW-1:0] num_i [NL],
  input  logic [WW-1:0] den_i,
  input  logic          neg_i [NL],
  output logic          vld_o,
  output side_t         side_o,
  output logic [QW-1:0] quo_o [NL],
  output logic          ovf_o [NL],
  output logic          neg_o [NL]
);

  logic          vld_q  [QW+1];
  side_t         side_q [QW+1];
  logic [WW-1:0] den_q  [QW+1];
  logic [WW-1:0] rem_q  [QW+1][NL];
  logic [QW-1:0] quo_q  [QW+1][NL];
  logic          ovf_q  [QW+1][NL];
  logic          neg_q  [QW+1][NL];

  // entry stage: flag quotients that need more than QW bits
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      side_q[0] <= side_i;
      den_q[0]  <= den_i;
      for (int l = 0; l < NL; l++) begin
        rem_q[0][l] <= num_i[l];
        quo_q[0][l] <= '0;
        ovf_q[0][l] <= (num_i[l] >> QW) >= den_i;
        neg_q[0][l] <= neg_i[l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv_i) begin
      vld_q[0] <= vld_i;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar s = 0; s < QW; s++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (adv_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        side_q[s+1] <= side_q[s];
        den_q[s+1]  <= den_q[s];
      end
    end

    for (genvar l = 0; l < NL; l++) begin : g_lane
      logic ge;
      assign ge = (rem_q[s][l] >> (QW-1-s)) >= den_q[s];

      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          rem_q[s+1][l] <= ge ? rem_q[s][l] - (den_q[s] << (QW-1-s)) : rem_q[s][l];
          quo_q[s+1][l] <= {quo_q[s][l][QW-2:0], ge};
          ovf_q[s+1][l] <= ovf_q[s][l];
          neg_q[s+1][l] <= neg_q[s][l];
        end
      end
    end
  end

  assign vld_o  = vld_q[QW];
  assign side_o = side_q[QW];
  assign quo_o  = quo_q[QW];
  assign ovf_o  = ovf_q[QW];
  assign neg_o  = neg_q[QW];

endmodule

>>> rtl/quad4_shape_gradient_jacobian.sv
// ----------------------------------------------------------------------------
// quad4_shape_gradient_jacobian: bilinear quad shape gradients at 2x2 Gauss
// Accepts one element (four nodal coordinates) and returns four Gauss-point
// results: global shape gradients, point volume and a singular flag.
// ----------------------------------------------------------------------------
// An element is taken when the last point of the one before moves on; one
// point result leaves every cycle unless the result side stalls. The four
// points of an element share one pipeline, so the sequencer sets the
// element rate. A point passes the sequencer, five stages of Jacobian and
// numerator arithmetic, 33 divider stages (overflow check, then one quotient
// bit each) and the output register. Result stalls freeze the whole pipeline.
module quad4_shape_gradient_jacobian import qsgj_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] node0_x_i,
  input  logic [31:0] node0_y_i,
  input  logic [31:0] node1_x_i,
  input  logic [31:0] node1_y_i,
  input  logic [31:0] node2_x_i,
  input  logic [31:0] node2_y_i,
  input  logic [31:0] node3_x_i,
  input  logic [31:0] node3_y_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  point_index_o,
  output logic [31:0] grad0_x_o,
  output logic [31:0] grad0_y_o,
  output logic [31:0] grad1_x_o,
  output logic [31:0] grad1_y_o,
  output logic [31:0] grad2_x_o,
  output logic [31:0] grad2_y_o,
  output logic [31:0] grad3_x_o,
  output logic [31:0] grad3_y_o,
  output logic [31:0] point_volume_o,
  output logic        singular_o,
  output logic        last_o
);

  logic          adv;
  coord_t        xin [NN];
  coord_t        yin [NN];
  logic          pt_vld;
  pt_t           pt;
  coord_t        xs [NN];
  coord_t        ys [NN];
  logic          j_vld;
  side_t         j_side;
  logic [WW-1:0] j_num [NL];
  logic [WW-1:0] j_den;
  logic          j_neg [NL];
  logic          d_vld;
  side_t         d_side;
  logic [QW-1:0] d_quo [NL];
  logic          d_ovf [NL];
  logic          d_neg [NL];
  logic [CW-1:0] g_d [NL];

  logic          out_vld_q;
  side_t         out_side_q;
  logic [CW-1:0] out_g_q [NL];

  // whole pipeline moves when the output register is free or drained
  assign adv = !out_vld_q || !out_stall_i;

  assign xin[0] = node0_x_i;
  assign xin[1] = node1_x_i;
  assign xin[2] = node2_x_i;
  assign xin[3] = node3_x_i;
  assign yin[0] = node0_y_i;
  assign yin[1] = node1_y_i;
  assign yin[2] = node2_y_i;
  assign yin[3] = node3_y_i;

  qsgj_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .x_i        (xin),
    .y_i        (yin),
    .adv_i      (adv),
    .in_stall_o (in_stall_o),
    .pt_valid_o (pt_vld),
    .pt_o       (pt),
    .x_o        (xs),
    .y_o        (ys)
  );

  qsgj_jac #(.FRAC_BITS(FRAC_BITS)) u_jac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .pt_valid_i (pt_vld),
    .pt_i       (pt),
    .x_i        (xs),
    .y_i        (ys),
    .vld_o      (j_vld),
    .side_o     (j_side),
    .num_o      (j_num),
    .den_o      (j_den),
    .neg_o      (j_neg)
  );

  qsgj_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (j_vld),
    .side_i (j_side),
    .num_i  (j_num),
    .den_i  (j_den),
    .neg_i  (j_neg),
    .vld_o  (d_vld),
    .side_o (d_side),
    .quo_o  (d_quo),
    .ovf_o  (d_ovf),
    .neg_o  (d_neg)
  );

  // apply sign and clamp quotients; drop gradients of a singular point
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      if (d_side.singular) begin
        g_d[l] = '0;
      end else if (d_neg[l]) begin
        g_d[l] = (d_ovf[l] || d_quo[l][QW-1]) ? 32'h8000_0000 : CW'(-d_quo[l]);
      end else begin
        g_d[l] = (d_ovf[l] || d_quo[l] >= 32'h7fff_ffff) ? 32'h7fff_ffff : d_quo[l];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= d_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_side_q.pt       <= d_side.pt;
      out_side_q.singular <= d_side.singular;
      out_side_q.vol      <= d_side.singular ? '0 : d_side.vol;
      out_g_q             <= g_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign point_index_o  = out_side_q.pt.idx;
  assign last_o         = out_side_q.pt.last;
  assign singular_o     = out_side_q.singular;
  assign point_volume_o = out_side_q.vol;
  assign grad0_x_o      = out_g_q[0];
  assign grad0_y_o      = out_g_q[1];
  assign grad1_x_o      = out_g_q[2];
  assign grad1_y_o      = out_g_q[3];
  assign grad2_x_o      = out_g_q[4];
  assign grad2_y_o      = out_g_q[5];
  assign grad3_x_o      = out_g_q[6];
  assign grad3_y_o      = out_g_q[7];

  // last marks the fourth point and only that one
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (point_index_o == PT_MP)))
    else $error("last flag does not match point index");

  // a singular point carries zero volume and zero gradients; grad0_x, grad1_y and grad3_x are checked
  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && singular_o) |-> (point_volume_o == '0 && grad0_x_o == '0 &&
      grad1_y_o == '0 && grad3_x_o == '0))
    else $error("singular point with non-zero result");

  // a new element is never taken while the sequencer still owes points
  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pt_vld && pt.idx != PT_MP) |-> in_stall_o)
    else $error("element taken before its four points were issued");

  // a fresh element always starts at the first Gauss point
  a_first_pt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (pt_vld && pt.idx == PT_MM))
    else $error("element did not start at the first point");

endmodule

>>> test/tb_quad4_shape_gradient_jacobian.sv
// ----------------------------------------------------------------------------
// tb_quad4_shape_gradient_jacobian: self-checking bench for the quad4 block
// Drives elements through a valid/stall channel with random gaps, predicts
// the four Gauss-point results of each element in fixed point and compares
// every returned transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_quad4_shape_gradient_jacobian;
  import qsgj_pkg::*;

  localparam int      FRAC       = 16;
  localparam longint  CONST_A    = 113454173;
  localparam longint  CONST_B    = 423416739;
  localparam int      CYCLE_CAP  = 400000;
  localparam int      DRAIN_WAIT = 60;

  typedef struct {
    logic [1:0]  idx;
    logic [31:0] grad [8];
    logic [31:0] vol;
    logic        sing;
    logic        last;
  } point_res_t;

  typedef logic [31:0] element_t [8];

  // round to nearest, half toward +infinity
  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // quotient rounded half away from zero, saturated
  function automatic longint quot_sat(longint n, longint d);
    logic [63:0] un, ud, q;
    logic        neg;
    un  = n < 0 ? 64'(-n) : 64'(n);
    ud  = d < 0 ? 64'(-d) : 64'(d);
    q   = (un + ud / 2) / ud;
    neg = (n < 0) != (d < 0);
    if (neg) return q >= 64'd2147483648 ? -64'sd2147483648 : -longint'(q);
    return q >= 64'd2147483647 ? 64'sd2147483647 : longint'(q);
  endfunction

  class gauss_scoreboard;
    point_res_t pending [$];
    int         errors;

    // predict the four points of an accepted element
    function void note_element(element_t e);
      longint x [4], y [4], dxi [4], deta [4];
      longint p, q, r, s, a0, a1, b0, b1, j00, j01, j10, j11, dq, nx, ny;
      point_res_t res;
      bit xp, ep;
      for (int m = 0; m < 4; m++) begin
        x[m] = longint'($signed(e[2*m]));
        y[m] = longint'($signed(e[2*m+1]));
      end
      for (int k = 0; k < 4; k++) begin
        xp = (k == PT_PM) || (k == PT_PP);
        ep = (k == PT_PP) || (k == PT_MP);
        p = ep ? CONST_A : CONST_B;
        q = ep ? CONST_B : CONST_A;
        r = xp ? CONST_A : CONST_B;
        s = xp ? CONST_B : CONST_A;
        dxi[0] = -p; dxi[1] = p; dxi[2] = q; dxi[3] = -q;
        deta[0] = -r; deta[1] = -s; deta[2] = s; deta[3] = r;
        a0 = 0; a1 = 0; b0 = 0; b1 = 0;
        for (int m = 0; m < 4; m++) begin
          a0 += dxi[m] * x[m];
          a1 += dxi[m] * y[m];
          b0 += deta[m] * x[m];
          b1 += deta[m] * y[m];
        end
        j00 = clamp32(rnd_shift(a0, 30));
        j01 = clamp32(rnd_shift(a1, 30));
        j10 = clamp32(rnd_shift(b0, 30));
        j11 = clamp32(rnd_shift(b1, 30));
        dq  = rnd_shift(j00 * j11 - j01 * j10, FRAC);
        res.idx  = 2'(k);
        res.last = (k == PT_MP);
        res.sing = (dq == 0);
        if (dq == 0) begin
          for (int m = 0; m < 8; m++) res.grad[m] = '0;
          res.vol = '0;
        end else begin
          for (int m = 0; m < 4; m++) begin
            nx = rnd_shift(j11 * dxi[m] - j01 * deta[m], 30 - FRAC);
            ny = rnd_shift(j00 * deta[m] - j10 * dxi[m], 30 - FRAC);
            res.grad[2*m]   = 32'(quot_sat(nx, dq));
            res.grad[2*m+1] = 32'(quot_sat(ny, dq));
          end
          res.vol = 32'(clamp32(dq));
        end
        pending.push_back(res);
      end
    endfunction

    // compare one returned point against the oldest prediction
    function void check_point(point_res_t act);
      point_res_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected point result idx=%0d", $time, act.idx);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (act.idx !== exp_r.idx) begin
        $display("%0t: point_index exp %0d got %0d", $time, exp_r.idx, act.idx);
        errors++;
      end
      for (int m = 0; m < 8; m++)
        if (act.grad[m] !== exp_r.grad[m]) begin
          $display("%0t: grad%0d_%s exp %h got %h", $time, m / 2, (m % 2) ? "y" : "x",
                   exp_r.grad[m], act.grad[m]);
          errors++;
        end
      if (act.vol !== exp_r.vol) begin
        $display("%0t: point_volume exp %h got %h", $time, exp_r.vol, act.vol);
        errors++;
      end
      if (act.sing !== exp_r.sing) begin
        $display("%0t: singular exp %b got %b", $time, exp_r.sing, act.sing);
        errors++;
      end
      if (act.last !== exp_r.last) begin
        $display("%0t: last exp %b got %b", $time, exp_r.last, act.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] node_i [8];
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  point_index_o;
  logic [31:0] grad_o [8];
  logic [31:0] point_volume_o;
  logic        singular_o, last_o;

  gauss_scoreboard sb = new();
  int  cycles = 0;
  bit  hold_off_req = 0;
  bit  no_idle = 0;

  initial for (int m = 0; m < 8; m++) node_i[m] = '0;

  quad4_shape_gradient_jacobian #(.FRAC_BITS(FRAC)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .node0_x_i(node_i[0]), .node0_y_i(node_i[1]),
    .node1_x_i(node_i[2]), .node1_y_i(node_i[3]),
    .node2_x_i(node_i[4]), .node2_y_i(node_i[5]),
    .node3_x_i(node_i[6]), .node3_y_i(node_i[7]),
    .out_valid_o, .out_stall_i, .point_index_o,
    .grad0_x_o(grad_o[0]), .grad0_y_o(grad_o[1]),
    .grad1_x_o(grad_o[2]), .grad1_y_o(grad_o[3]),
    .grad2_x_o(grad_o[4]), .grad2_y_o(grad_o[5]),
    .grad3_x_o(grad_o[6]), .grad3_y_o(grad_o[7]),
    .point_volume_o, .singular_o, .last_o
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // watch both channels and bound the run
  always @(posedge clk_i) begin
    point_res_t act;
    element_t   e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Mismatches found");
      $finish;
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      for (int m = 0; m < 8; m++) e[m] = node_i[m];
      sb.note_element(e);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      act.idx  = point_index_o;
      act.grad = grad_o;
      act.vol  = point_volume_o;
      act.sing = singular_o;
      act.last = last_o;
      sb.check_point(act);
    end
  end

  // receiver: random stall per transaction, one long hold-off on request
  initial begin
    int w;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 0;
        w = 300;
      end else begin
        w = (no_idle || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
      end
      if (w > 0) begin
        out_stall_i <= 1'b1;
        repeat (w) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  // offer one element, keep valid high into the next one when no gap
  task automatic send_element(element_t e);
    int gap;
    gap = (no_idle || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    for (int m = 0; m < 8; m++) node_i[m] <= e[m];
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
  endtask

  // axis-aligned rectangle with corner at (bx,by) and sides sx,sy
  function automatic element_t quad_of(logic [31:0] bx, logic [31:0] by,
                                       logic [31:0] sx, logic [31:0] sy);
    element_t e;
    e[0] = bx;      e[1] = by;
    e[2] = bx + sx; e[3] = by;
    e[4] = bx + sx; e[5] = by + sy;
    e[6] = bx;      e[7] = by + sy;
    return e;
  endfunction

  function automatic element_t rand_element();
    element_t e;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      // well-formed quad of modest size with jittered corners
      e = quad_of($urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000,
                  $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000,
                  $urandom_range(1, 32'h0008_0000), $urandom_range(1, 32'h0008_0000));
      for (int m = 0; m < 8; m++) e[m] += $urandom_range(0, 32'h3fff) - 32'h2000;
    end else if (sel < 8) begin
      for (int m = 0; m < 8; m++) e[m] = $urandom();
    end else begin
      // tiny or degenerate shapes near the singular boundary
      for (int m = 0; m < 8; m++) e[m] = $urandom_range(0, 7) - 3;
    end
    return e;
  endfunction

  initial begin
    element_t e;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero, unit square, inverted, extremes, degenerate, bit patterns
    for (int m = 0; m < 8; m++) e[m] = '0;
    send_element(e);
    send_element(quad_of(0, 0, 32'h0001_0000, 32'h0001_0000));
    send_element(quad_of(0, 0, 32'h0002_0000, 32'h0001_0000));
    send_element(quad_of(0, 0, 32'hffff_0000, 32'h0001_0000));
    send_element(quad_of(32'h0001_0000, 0, 32'h0003_0000, 32'h0000_0010));
    send_element(quad_of(0, 0, 1, 1));
    send_element(quad_of(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff));
    for (int m = 0; m < 8; m++) e[m] = (m % 3 == 0) ? 32'h8000_0000 : 32'h7fff_ffff;
    send_element(e);
    for (int m = 0; m < 8; m++) e[m] = (m % 2) ? 32'h5555_5555 : 32'haaaa_aaaa;
    send_element(e);
    for (int m = 0; m < 8; m++) e[m] = (m % 2) ? 32'haaaa_aaaa : 32'h5555_5555;
    send_element(e);
    for (int m = 0; m < 8; m++) e[m] = 32'hffff_ffff;
    send_element(e);
    // collinear nodes: zero area
    e[0] = 0; e[1] = 0; e[2] = 32'h0001_0000; e[3] = 0;
    e[4] = 32'h0002_0000; e[5] = 0; e[6] = 32'h0003_0000; e[7] = 0;
    send_element(e);
    send_element(quad_of(0, 0, 32'h4000_0000, 32'h0000_0100));
    send_element(quad_of(32'h1234_5678, 32'hedcb_a988, 32'h0000_0003, 32'hfff0_0000));

    // random, back-to-back burst with a long receiver hold-off
    no_idle = 1;
    hold_off_req = 1;
    repeat (20) send_element(rand_element());
    no_idle = 0;

    // drain completely before carrying on
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (70) send_element(rand_element());

    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
